[design/swee_pkg.sv]
package swee_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_EXMIN = 2'd2,
        OP_EXMAX = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_COMPACT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

[design/swee_mem.sv]
module swee_mem #(
    parameter int DEPTH = swee_pkg::DEPTH_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  swee_pkg::mem_ctl_t          ctl,
    input  logic [AW-1:0]               raddr,
    input  logic [AW-1:0]               waddr,
    input  logic [swee_pkg::DATA_W-1:0] wdata,
    output logic [swee_pkg::DATA_W-1:0] rdata
);

    logic [swee_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/stack_with_extract_extremum.sv]
// Push and any rejected transaction finish from the idle state; pop passes through S_POP, and
// extract sweeps the entries in S_SCAN, then compacts them in S_COMPACT.
// Start is ignored while busy; the next start is taken in the done cycle; extract
// time is set by the single read port of entry memory, swept for the extremum then compacted.
// Reset: rst_n clears the stack count and control state; fill_count and entry memory are not cleared.
// Results are strobed for one cycle on done; the receiver cannot stall.
module stack_with_extract_extremum #(
    parameter int DEPTH = swee_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] push_value,
    output logic        done,
    output logic [31:0] out_value,
    output logic [1:0]  status,
    output logic [3:0]  fill_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    swee_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [31:0]      best_reg, best_next;
    logic [31:0]      out_value_reg, out_value_next;
    swee_pkg::status_t status_reg, status_next;
    logic             first_reg, first_next;
    logic             want_max_reg, want_max_next;
    logic             rvalid_reg, rvalid_next;
    logic             done_reg, done_next;

    swee_pkg::mem_ctl_t ctl;
    logic [AW-1:0]      raddr, waddr;
    logic [31:0]        wdata, rdata;
    logic [CW-1:0]      top_idx;
    logic               sweep_end;
    logic               better;
    logic [CW+3:0]      fill_wide;
    swee_pkg::opcode_t  op;

    swee_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .ctl   (ctl),
        .raddr (raddr),
        .waddr (waddr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign op        = swee_pkg::opcode_t'(opcode);
    assign top_idx   = count_reg - CW'(1);
    assign sweep_end = (idx_reg == count_reg) && !rvalid_reg;
    assign better    = want_max_reg ? ($signed(rdata) > $signed(best_reg))
                                    : ($signed(rdata) < $signed(best_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swee_pkg::S_IDLE:
            begin
                if (start && (op != swee_pkg::OP_PUSH) && (count_reg != '0))
                begin
                    state_next = (op == swee_pkg::OP_POP) ? swee_pkg::S_POP
                                                          : swee_pkg::S_SCAN;
                end
            end
            swee_pkg::S_POP:
            begin
                state_next = swee_pkg::S_IDLE;
            end
            swee_pkg::S_SCAN:
            begin
                if (sweep_end)
                begin
                    state_next = swee_pkg::S_COMPACT;
                end
            end
            swee_pkg::S_COMPACT:
            begin
                if (sweep_end)
                begin
                    state_next = swee_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = swee_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        fill_next      = fill_reg;
        best_next      = best_reg;
        first_next     = first_reg;
        want_max_next  = want_max_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        rvalid_next    = 1'b0;
        done_next      = 1'b0;
        ctl.rd_en      = 1'b0;
        ctl.wr_en      = 1'b0;
        raddr          = idx_reg[AW-1:0];
        waddr          = kept_reg[AW-1:0];
        wdata          = rdata;
        case (state_reg)
            swee_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (op == swee_pkg::OP_PUSH)
                    begin
                        done_next      = 1'b1;
                        out_value_next = '0;
                        if (count_reg == DEPTH_C)
                        begin
                            status_next = swee_pkg::ST_FULL;
                            fill_next   = count_reg;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            waddr       = count_reg[AW-1:0];
                            wdata       = push_value;
                            count_next  = count_reg + CW'(1);
                            fill_next   = count_reg + CW'(1);
                            status_next = swee_pkg::ST_OK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next      = 1'b1;
                        out_value_next = '0;
                        status_next    = swee_pkg::ST_EMPTY;
                        fill_next      = count_reg;
                    end
                    else if (op == swee_pkg::OP_POP)
                    begin
                        ctl.rd_en   = 1'b1;
                        raddr       = top_idx[AW-1:0];
                        rvalid_next = 1'b1;
                    end
                    else
                    begin
                        want_max_next = (op == swee_pkg::OP_EXMAX);
                        idx_next      = '0;
                        first_next    = 1'b1;
                    end
                end
            end
            swee_pkg::S_POP:
            begin
                done_next      = 1'b1;
                out_value_next = rdata;
                status_next    = swee_pkg::ST_OK;
                count_next     = top_idx;
                fill_next      = top_idx;
            end
            swee_pkg::S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    ctl.rd_en   = 1'b1;
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || better)
                    begin
                        best_next = rdata;
                    end
                end
                if (sweep_end)
                begin
                    idx_next  = '0;
                    kept_next = '0;
                end
            end
            swee_pkg::S_COMPACT:
            begin
                if (idx_reg < count_reg)
                begin
                    ctl.rd_en   = 1'b1;
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CW'(1);
                end
                if (rvalid_reg && (rdata != best_reg))
                begin
                    ctl.wr_en = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                if (sweep_end)
                begin
                    done_next      = 1'b1;
                    out_value_next = best_reg;
                    status_next    = swee_pkg::ST_OK;
                    count_next     = kept_reg;
                    fill_next      = kept_reg;
                end
            end
            default:
            begin
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swee_pkg::S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        kept_reg      <= kept_next;
        fill_reg      <= fill_next;
        best_reg      <= best_next;
        first_reg     <= first_next;
        want_max_reg  <= want_max_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign fill_wide  = {4'b0000, fill_reg};
    assign busy       = (state_reg != swee_pkg::S_IDLE);
    assign done       = done_reg;
    assign out_value  = out_value_reg;
    assign status     = status_reg;
    assign fill_count = fill_wide[3:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a transaction");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != swee_pkg::ST_OK)) |-> (out_value == '0))
        else $error("nonzero value on rejected transaction");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == swee_pkg::S_COMPACT) && ctl.wr_en) |-> (kept_reg < idx_reg))
        else $error("compaction write overtakes read");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy)) |-> !done)
        else $error("result strobed on multi-cycle start");
`endif

endmodule
